>>> rtl/hsbd_pkg.sv
// Shared types and constants for the half-scale box downsampler.
`timescale 1ns / 1ps
`default_nettype none

package hsbd_pkg;

    // Field and register widths.
    localparam int PIXEL_W = 8;
    localparam int LEN_W   = 12;
    localparam int TOT_W   = 16;
    localparam int PAIR_W  = 9;
    localparam int SUM_W   = 10;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register reset values.
    localparam logic [LEN_W-1:0] LINE_LENGTH_RST = 12'd640;
    localparam logic [TOT_W-1:0] LINE_TOTAL_RST  = 16'd480;

    // Register selects, taken from address bit 2.
    typedef enum logic {
        REG_LINE_LENGTH = 1'b0,
        REG_LINE_TOTAL  = 1'b1
    } reg_sel_t;

    // Effective frame geometry handed from the register block to the datapath.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [TOT_W-1:0] tot;
        logic [LEN_W-1:0] last_col;
        logic [TOT_W-1:0] last_line;
    } geometry_t;

endpackage : hsbd_pkg

`default_nettype wire

>>> rtl/hsbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hsbd_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : hsbd_ram

`default_nettype wire

>>> rtl/hsbd_cfg.sv
// APB register block and effective frame geometry for the downsampler.
`timescale 1ns / 1ps
`default_nettype none

module hsbd_cfg #(
    parameter int MAX_LINE = 2048
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hsbd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [hsbd_pkg::APB_DW-1:0]   pwdata,
    output logic      [hsbd_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output hsbd_pkg::geometry_t                geom
);
    import hsbd_pkg::*;

    // Largest line length that the 12-bit register can ask for and the store can hold.
    localparam int MaxLen = (MAX_LINE > 4095) ? 4095 : MAX_LINE;

    logic [LEN_W-1:0] line_length_reg;
    logic [TOT_W-1:0] line_total_reg;
    logic             wr_en;
    reg_sel_t         sel;
    logic [LEN_W-1:0] len_eff;
    logic [TOT_W-1:0] tot_eff;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = reg_sel_t'(paddr[2]);

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= LINE_LENGTH_RST;
            line_total_reg  <= LINE_TOTAL_RST;
        end else if (wr_en) begin
            unique case (sel)
                REG_LINE_LENGTH: line_length_reg <= pwdata[LEN_W-1:0];
                REG_LINE_TOTAL:  line_total_reg  <= pwdata[TOT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (sel)
            REG_LINE_LENGTH: prdata = {{(APB_DW-LEN_W){1'b0}}, line_length_reg};
            REG_LINE_TOTAL:  prdata = {{(APB_DW-TOT_W){1'b0}}, line_total_reg};
            default:         prdata = '0;
        endcase
    end

    // A zero size acts as one; a line longer than the store is clipped.
    always_comb begin
        if (line_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(line_length_reg) > MaxLen) begin
            len_eff = LEN_W'(MaxLen);
        end else begin
            len_eff = line_length_reg;
        end
        tot_eff = (line_total_reg == '0) ? TOT_W'(1) : line_total_reg;
    end

    // Last odd column and last odd line of the frame. With fewer than two
    // columns or lines these wrap, but then nothing is ever emitted.
    assign geom.len       = len_eff;
    assign geom.tot       = tot_eff;
    assign geom.last_col  = {len_eff[LEN_W-1:1], 1'b0} - LEN_W'(1);
    assign geom.last_line = {tot_eff[TOT_W-1:1], 1'b0} - TOT_W'(1);

endmodule : hsbd_cfg

`default_nettype wire

>>> rtl/half_scale_box_downsample.sv
// Top level: 2x2 box-filter downsampler for an 8-bit grayscale pixel stream.
// Throughput: one pixel per cycle unless output stalls; one store write or read per pair.
// The request that completes a block passes the read stage, then the output register.
// Each odd-line pair sum goes through a line-store read and an output register.
// Reset (aresetn, synchronous, active low) clears counters, held pixel and valid flags;
// the line store is not cleared, every entry is written on an even line before it is read.
`timescale 1ns / 1ps
`default_nettype none

module half_scale_box_downsample #(
    parameter int MAX_LINE = 2048
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Pixel input; s_tdata[7:0] = pixel.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    // Downsampled output; m_tdata[7:0] = pixel_out, m_tlast = frame_end.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [7:0]                    m_tdata,
    output logic                               m_tlast,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hsbd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [hsbd_pkg::APB_DW-1:0]   pwdata,
    output logic      [hsbd_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import hsbd_pkg::*;

    localparam int CW    = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
    localparam int DEPTH = MAX_LINE / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW  = ((CW > LEN_W) ? CW : LEN_W) + 1;

    geometry_t geom;

    logic [CW-1:0]      col_reg,   col_next;
    logic [TOT_W-1:0]   line_reg,  line_next;
    logic [PIXEL_W-1:0] held_reg;
    logic               v1_reg;
    logic [PAIR_W-1:0]  pair1_reg;
    logic               last1_reg;
    logic               m_tvalid_reg;
    logic [PIXEL_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;

    logic               accept;
    logic               out_free;
    logic               in_frame;
    logic               pair_step;
    logic               wr_en;
    logic               rd_en;
    logic [CMPW-1:0]    col_ext;
    logic [CMPW-1:0]    col_inc;
    logic [CMPW-1:0]    len_ext;
    logic [TOT_W:0]     line_inc;
    logic [CW-1:0]      col_half;
    logic [AW-1:0]      slot;
    logic [PAIR_W-1:0]  pair;
    logic               last_hit;
    logic [PAIR_W-1:0]  rd_data;
    logic [SUM_W-1:0]   sum;

    hsbd_cfg #(
        .MAX_LINE (MAX_LINE)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    // Handshake: the read stage moves on whenever the output register frees up.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !v1_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // Position decode for the incoming pixel.
    assign col_ext   = CMPW'(col_reg);
    assign len_ext   = CMPW'(geom.len);
    assign in_frame  = (col_ext < len_ext) && (line_reg < geom.tot);
    assign pair_step = accept && in_frame && col_reg[0];
    assign wr_en     = pair_step && !line_reg[0];
    assign rd_en     = pair_step && line_reg[0];
    assign col_half  = col_reg >> 1;
    assign slot      = col_half[AW-1:0];
    assign pair      = PAIR_W'(held_reg) + PAIR_W'(s_tdata);
    assign last_hit  = (col_ext == CMPW'(geom.last_col)) && (line_reg == geom.last_line);

    // Column and line counters with wrap at end of line and end of frame.
    assign col_inc  = col_ext + CMPW'(1);
    assign line_inc = {1'b0, line_reg} + (TOT_W+1)'(1);
    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        if (accept) begin
            if (col_inc >= len_ext) begin
                col_next  = '0;
                line_next = (line_inc >= {1'b0, geom.tot}) ? '0 : line_inc[TOT_W-1:0];
            end else begin
                col_next  = col_inc[CW-1:0];
                line_next = (line_reg >= geom.tot) ? '0 : line_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= '0;
            held_reg <= '0;
        end else begin
            col_reg  <= col_next;
            line_reg <= line_next;
            if (accept && in_frame && !col_reg[0]) begin
                held_reg <= s_tdata;
            end
        end
    end

    // Line store of pair sums. An entry is written on an even line and read on the
    // odd line after it, at least one full line later, so no forwarding is needed.
    hsbd_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pair_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (slot),
        .wdata (pair),
        .re    (rd_en),
        .raddr (slot),
        .rdata (rd_data)
    );

    // Read stage: carries the new pair sum and frame-end flag beside the store read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (accept) begin
            v1_reg <= rd_en;
        end else if (out_free) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            pair1_reg <= pair;
            last1_reg <= last_hit;
        end
    end

    // Output register: four-pixel sum divided by four.
    assign sum = SUM_W'(rd_data) + SUM_W'(pair1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && v1_reg) begin
            m_tdata_reg <= sum[SUM_W-1:2];
            m_tlast_reg <= last1_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // Input stalls only while a store read waits behind a full output register.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // A finished read moves to the output when the output register is free.
    a_read_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && out_free) |=> m_tvalid_reg)
        else $error("read result lost on its way to the output");

    // The store is read only on odd lines and written only on even lines.
    a_read_odd_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en |-> line_reg[0]) and (wr_en |-> !line_reg[0]))
        else $error("line store accessed on the wrong line parity");

    // The column counter never leaves the line store's range.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) < MAX_LINE)
        else $error("column counter out of range");
`endif

endmodule : half_scale_box_downsample

`default_nettype wire

>>> test/half_scale_box_downsample_tb.sv
// Self-checking testbench for the 2x2 box-filter downsampler, checked against a built-in predictor.
`timescale 1ns / 1ps

module half_scale_box_downsample_tb;
    import hsbd_pkg::*;

    localparam int          MAX_LINE      = 2048;
    localparam int          PAIR_SLOTS    = MAX_LINE / 2;
    localparam int          CLK_PERIOD    = 10;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned RANDOM_PIXELS = 1300;

    // One expected output pixel: the block mean and the end-of-frame flag.
    typedef struct packed {
        logic [PIXEL_W-1:0] mean;
        logic               frame_end;
    } block_mean_t;

    // Predicts the mean of every 2x2 block and checks the output stream against it.
    class block_mean_board;
        logic [LEN_W-1:0]   line_length;
        logic [TOT_W-1:0]   line_total;
        logic [PAIR_W-1:0]  pair_sums [PAIR_SLOTS];
        logic [10:0]        column_pos;
        logic [15:0]        line_pos;
        logic [PIXEL_W-1:0] held_pixel;
        block_mean_t        pending_means [$];
        int                 failures;
        int                 pixels_taken;
        int                 means_checked;
        int                 frame_ends;

        function new();
            line_length   = LINE_LENGTH_RST;
            line_total    = LINE_TOTAL_RST;
            column_pos    = '0;
            line_pos      = '0;
            held_pixel    = '0;
            failures      = 0;
            pixels_taken  = 0;
            means_checked = 0;
            frame_ends    = 0;
            foreach (pair_sums[i]) pair_sums[i] = '0;
        endfunction

        function void set_register(reg_sel_t sel, logic [APB_DW-1:0] value);
            if (sel == REG_LINE_LENGTH) begin
                line_length = value[LEN_W-1:0];
            end else begin
                line_total = value[TOT_W-1:0];
            end
        endfunction

        // True at the first column of an even line, where the geometry may change safely.
        function bit at_even_line_start();
            return column_pos == '0 && line_pos[0] == 1'b0;
        endfunction

        function int expected_count();
            return pending_means.size();
        endfunction

        // Advances the predictor by one accepted pixel request.
        function void take_pixel(logic [PIXEL_W-1:0] pix);
            int unsigned len;
            int unsigned tot;
            int unsigned col;
            int unsigned ln;
            int unsigned slot;
            int unsigned pair;
            int unsigned total;
            int unsigned last_col;
            int unsigned last_line;
            block_mean_t item;
            len = (line_length == '0) ? 32'd1 : 32'(line_length);
            if (len > MAX_LINE) len = MAX_LINE;
            tot = (line_total == '0) ? 32'd1 : 32'(line_total);
            col = 32'(column_pos);
            ln  = 32'(line_pos);
            pixels_taken++;

            // Pixels outside the current geometry are dropped.
            if (col < len && ln < tot) begin
                if ((col & 1) == 0) begin
                    held_pixel = pix;
                end else begin
                    slot = (col >> 1) % PAIR_SLOTS;
                    pair = (32'(held_pixel) + 32'(pix)) & 32'h1FF;
                    if ((ln & 1) == 0) begin
                        pair_sums[slot] = PAIR_W'(pair);
                    end else begin
                        total          = 32'(pair_sums[slot]) + pair;
                        last_col       = (len & ~32'd1) - 1;
                        last_line      = (tot & ~32'd1) - 1;
                        item.mean      = PIXEL_W'(total >> 2);
                        item.frame_end = (col == last_col && ln == last_line);
                        pending_means.push_back(item);
                    end
                end
            end

            // Column wraps at the end of a line, line wraps at the end of the frame.
            col++;
            if (col >= len) begin
                col = 0;
                ln++;
                if (ln >= tot) ln = 0;
            end else if (ln >= tot) begin
                ln = 0;
            end
            column_pos = 11'(col);
            line_pos   = 16'(ln);
        endfunction

        // Compares one accepted output request with the oldest expected mean.
        function void check_result(logic [PIXEL_W-1:0] mean, logic last);
            block_mean_t want;
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected output pixel %0d (last %0b)", $time, mean, last);
                failures++;
                return;
            end
            want = pending_means.pop_front();
            if (mean !== want.mean) begin
                $display("%0t: pixel_out expected %0d, got %0d", $time, want.mean, mean);
                failures++;
            end
            if (last !== want.frame_end) begin
                $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end, last);
                failures++;
            end
            means_checked++;
            if (last) frame_ends++;
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;   // [7:0] pixel
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;         // [7:0] pixel_out
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    block_mean_board      board = new();
    int unsigned          send_gap_pct = 0;
    int unsigned          stall_pct    = 0;
    int unsigned          cycle_count  = 0;
    int                   phase_count  = 0;

    // One frame of 4x4 pixels covering saturation, zero and truncation.
    logic [PIXEL_W-1:0] corner_frame [16] = '{
        8'd255, 8'd255, 8'd0,   8'd0,
        8'd255, 8'd255, 8'd1,   8'd1,
        8'd3,   8'd3,   8'h80,  8'h7F,
        8'd3,   8'd2,   8'h55,  8'hAA
    };

    half_scale_box_downsample #(
        .MAX_LINE (MAX_LINE)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // The receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Every accepted request on either side goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.take_pixel(s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
        end
    end

    // A run that hangs ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("half_scale_box_downsample_tb failed");
            $finish;
        end
    end

    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom_range(255));
        endcase
    endfunction

    // Writes one register, then reads it back.
    task automatic write_register(input reg_sel_t sel, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] stored;
        stored = (sel == REG_LINE_LENGTH) ? APB_DW'(value[LEN_W-1:0])
                                          : APB_DW'(value[TOT_W-1:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_register(sel, value);

        // Read-back of the same register.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== stored) begin
            $display("%0t: register %s read expected %0d, got %0d",
                     $time, sel.name(), stored, prdata);
            board.failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one pixel request, with random idle cycles ahead of it.
    task automatic push_pixel(input logic [PIXEL_W-1:0] pix);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits for every expected mean, then lets any dropped pixel leave the pipeline.
    task automatic wait_drained();
        do @(posedge aclk); while (board.expected_count() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One geometry setting: random pixels, then padding up to the start of an even line.
    task automatic run_phase(input int unsigned len, input int unsigned tot,
                             input int unsigned pixels);
        phase_count++;
        case (phase_count % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 58; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 58; end
            default: begin send_gap_pct = 9; stall_pct = 9; end
        endcase
        write_register(REG_LINE_LENGTH, APB_DW'(len));
        write_register(REG_LINE_TOTAL, APB_DW'(tot));
        repeat (pixels) push_pixel(random_pixel());
        s_tvalid <= 1'b0;
        @(posedge aclk);

        // Stopping at an even line start keeps every line-store read behind its write.
        while (!board.at_even_line_start()) begin
            push_pixel(random_pixel());
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        wait_drained();
    endtask

    initial begin
        int unsigned len;
        int unsigned tot;
        int unsigned pixels;
        int unsigned random_sent;
        random_sent = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed 4x4 frame with no idling.
        write_register(REG_LINE_LENGTH, 32'd4);
        write_register(REG_LINE_TOTAL, 32'd4);
        foreach (corner_frame[i]) push_pixel(corner_frame[i]);
        s_tvalid <= 1'b0;
        wait_drained();

        // Zero sizes act as one, so nothing comes out.
        run_phase(0, 0, 6);
        // Single-column and single-line frames.
        run_phase(1, 6, 8);
        run_phase(7, 1, 10);
        // Odd sizes drop the trailing column and line; a 2x2 frame follows.
        run_phase(3, 5, 30);
        run_phase(2, 2, 40);
        // Largest line count, then a smaller one written while past its last line.
        run_phase(2, 32'hFFFF, 120);
        run_phase(6, 9, 100);

        // Random geometries, mostly small.
        while (random_sent < RANDOM_PIXELS) begin
            case ($urandom_range(19))
                0: len = 0;
                1, 2, 3: len = $urandom_range(80, 13);
                default: len = $urandom_range(12, 1);
            endcase
            case ($urandom_range(19))
                0: tot = 0;
                1, 2: tot = $urandom_range(40, 11);
                default: tot = $urandom_range(10, 1);
            endcase
            pixels = $urandom_range(160, 20);
            run_phase(len, tot, pixels);
            random_sent += pixels;
        end

        $display("Covered %0d pixel requests and %0d averaged outputs (%0d frame ends).",
                 board.pixels_taken, board.means_checked, board.frame_ends);
        $display("Used %0d geometry settings from one-pixel lines to lines of 80 pixels.",
                 phase_count + 1);
        if (board.failures == 0) begin
            $display("half_scale_box_downsample_tb passed");
        end else begin
            $display("half_scale_box_downsample_tb failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/hsbd_pkg.sv
rtl/hsbd_ram.sv
rtl/hsbd_cfg.sv
rtl/half_scale_box_downsample.sv
test/half_scale_box_downsample_tb.sv
